>>> hw/rtl/tlk_pkg.sv
// Shared widths, constants and arctangent table for the two-link arm kinematics block.
`default_nettype none
package tlk_pkg;

  localparam int MAX_SECTIONS_DEF = 64;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CW  = 52;  // CORDIC vector width
  localparam int ZW  = 26;  // CORDIC angle width, 2^-16 degree
  localparam int DVW = 62;  // divider dividend width
  localparam int DSW = 31;  // divider divisor width

  localparam logic [14:0] UPPER_RESET = 15'd512;
  localparam logic [14:0] LOWER_RESET = 15'd256;

  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);
  localparam logic signed [31:0]   ONE_Q30 = 32'sd1073741824;

  localparam logic [14:0] ELBOW_MAX = 15'd23040;
  localparam int          SHOULDER_LIM = 46080;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tlk_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module tlk_div import tlk_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                done,
  output logic [DVW-1:0]      quotient
);

  localparam int CNTW = $clog2(DVW);

  logic [DVW-1:0]  q_r;
  logic [DSW-1:0]  rem_r;
  logic [DSW-1:0]  dsr_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DSW:0]    shifted;
  logic [DSW+1:0]  diff;

  assign shifted  = {rem_r, q_r[DVW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dsr_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(DVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DSW+1]) begin
        rem_r <= diff[DSW-1:0];
        q_r   <= {q_r[DVW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DSW-1:0];
        q_r   <= {q_r[DVW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tlk_cordic.sv
// Vectoring CORDIC atan2, one micro-rotation per cycle.
`default_nettype none
module tlk_cordic import tlk_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [CW-1:0] x0,
  input  wire logic signed [CW-1:0] y0,
  output logic                      done,
  output logic signed [ZW-1:0]      z
);

  localparam int IW = $clog2(STEPS);

  logic signed [CW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r, tab;
  logic [IW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 zero_in;
  logic                 y_pos;

  assign zero_in = (x0 == '0) && (y0 == '0);
  assign xs      = x_r >>> cnt_r;
  assign ys      = y_r >>> cnt_r;
  assign tab     = atan_entry(5'(cnt_r));
  assign y_pos   = !y_r[CW-1] && (y_r != '0);
  assign done    = done_r;
  assign z       = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= '0;
        busy_r <= !zero_in;
        done_r <= zero_in;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (x0[CW-1] && !y0[CW-1]) begin
        x_r <= y0;
        y_r <= -x0;
        z_r <= DEG90;
      end else if (x0[CW-1]) begin
        x_r <= -y0;
        y_r <= x0;
        z_r <= -DEG90;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (y_pos) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + tab;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - tab;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/two_link_arm_line_kinematics.sv
// Top level: straight-line stepping of a two-link arm with inverse kinematics per step.
// Sequence: after acceptance, delta setup runs two divisions (x then y) by the section count.
// Each step then runs a division (skipped when the point is out of reach), a square root,
// three CORDIC runs and eight shared multiplies, then waits in S_FIN until the output
// register is free.
// Throughput: one transaction per line, sections steps; not ready until the last step.
// Reset: synchronous active-low; lengths return to 512/256, pen to (0, 768).
`default_nettype none
module two_link_arm_line_kinematics import tlk_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // target_x, target_y, sections
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // pos_x, pos_y, shoulder_angle, elbow_angle
  output logic [0:0]       out_tuser,  // out_of_reach
  output logic             out_tlast
);

  localparam int SW = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [24:0] {
    S_IDLE = 25'h0000001, S_DX  = 25'h0000002, S_DXW = 25'h0000004,
    S_DY   = 25'h0000008, S_DYW = 25'h0000010, S_STEP = 25'h0000020,
    S_MXX  = 25'h0000040, S_MYY = 25'h0000080, S_ML1 = 25'h0000100,
    S_ML2  = 25'h0000200, S_MLL = 25'h0000400, S_CHK = 25'h0000800,
    S_CW   = 25'h0001000, S_CC  = 25'h0002000, S_SQI = 25'h0004000,
    S_SQ   = 25'h0008000, S_EL  = 25'h0010000, S_ELW = 25'h0020000,
    S_A1   = 25'h0040000, S_A1W = 25'h0080000, S_P1  = 25'h0100000,
    S_P2   = 25'h0200000, S_A2  = 25'h0400000, S_A2W = 25'h0800000,
    S_FIN  = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0]          upper_r, lower_r;
  logic signed [15:0]   pen_x_r, pen_y_r, tx_r, ty_r;
  logic [SW-1:0]        sec_r, k_r, sec_in;
  logic signed [16:0]   dx_r, dy_r, diff;
  logic                 dneg_r;
  logic signed [63:0]   prod_r, acc_r, den;
  logic signed [31:0]   mul_a, mul_b, c_r;
  logic                 nneg_r, oor_r;
  logic [62:0]          sq_n_r, sq_res_r, sq_bit_r, sq_sum;
  logic [14:0]          e_r;
  logic signed [ZW-1:0] a1_r;
  logic signed [63:0]   ya_r;
  logic                 clamp;
  logic [63:0]          num_mag;

  logic                 div_start, div_done;
  logic [DVW-1:0]       div_dvd, div_q;
  logic [DSW-1:0]       div_dsr;
  logic                 cor_start, cor_done;
  logic signed [CW-1:0] cor_x, cor_y;
  logic signed [ZW-1:0] cor_z;

  logic                 out_tvalid_r, out_free, last_step;
  logic signed [15:0]   ox_r, oy_r;
  logic signed [16:0]   osh_r;
  logic [14:0]          oel_r;
  logic                 ooor_r, olast_r;
  logic signed [ZW:0]   e_rnd, d_rnd;
  logic signed [16:0]   d_clamped;

  function automatic logic signed [ZW:0] to_units(input logic signed [ZW:0] v);
    logic signed [ZW:0] mag;
    logic signed [ZW:0] r;
    mag = v[ZW] ? -v : v;
    r   = (mag + (ZW+1)'(256)) >>> 9;
    return v[ZW] ? -r : r;
  endfunction

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {17'b0, lower_r} : {17'b0, upper_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RESET;
      lower_r <= LOWER_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2]) lower_r <= cfg_pwdata[14:0];
      else              upper_r <= cfg_pwdata[14:0];
    end
  end

  // handshake
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {oel_r, osh_r, oy_r, ox_r};
  assign out_tuser  = ooor_r;
  assign out_tlast  = olast_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign last_step  = (k_r == sec_r - 1'b1);

  always_comb begin
    if (in_tdata[38:32] == 7'd0)                 sec_in = SW'(1);
    else if (32'(in_tdata[38:32]) > MAX_SECTIONS) sec_in = SW'(MAX_SECTIONS);
    else                                          sec_in = SW'(in_tdata[38:32]);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MXX: begin mul_a = 32'(pen_x_r); mul_b = 32'(pen_x_r); end
      S_MYY: begin mul_a = 32'(pen_y_r); mul_b = 32'(pen_y_r); end
      S_ML1: begin mul_a = {17'b0, upper_r}; mul_b = {17'b0, upper_r}; end
      S_ML2: begin mul_a = {17'b0, lower_r}; mul_b = {17'b0, lower_r}; end
      S_MLL: begin mul_a = {17'b0, upper_r}; mul_b = {17'b0, lower_r}; end
      S_CC:  begin mul_a = c_r; mul_b = c_r; end
      S_P1:  begin mul_a = {17'b0, lower_r}; mul_b = {1'b0, sq_res_r[30:0]}; end
      S_P2:  begin mul_a = {17'b0, lower_r}; mul_b = c_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider operands
  assign den     = prod_r <<< 1;
  assign clamp   = (den == '0) || (acc_r > den) || (acc_r < -den);
  assign num_mag = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
  assign diff    = (state_r == S_DX) ? (17'(tx_r) - 17'(pen_x_r))
                                     : (17'(ty_r) - 17'(pen_y_r));

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = DSW'(sec_r);
    case (state_r)
      S_DX, S_DY: begin
        div_start = 1'b1;
        div_dvd   = DVW'(diff[16] ? 17'(-diff) : diff);
      end
      S_CHK: begin
        div_start = !clamp;
        div_dvd   = DVW'({num_mag[30:0], 30'b0});
        div_dsr   = den[DSW-1:0];
      end
      default: div_start = 1'b0;
    endcase
  end

  // CORDIC operands
  always_comb begin
    cor_start = 1'b0;
    cor_x     = '0;
    cor_y     = '0;
    case (state_r)
      S_EL: begin
        cor_start = 1'b1;
        cor_x     = CW'(c_r);
        cor_y     = CW'({1'b0, sq_res_r[30:0]});
      end
      S_A1: begin
        cor_start = 1'b1;
        cor_x     = CW'(pen_x_r) <<< 30;
        cor_y     = CW'(pen_y_r) <<< 30;
      end
      S_A2: begin
        cor_start = 1'b1;
        cor_x     = (CW'({1'b0, upper_r}) <<< 30) + CW'(prod_r);
        cor_y     = CW'(ya_r);
      end
      default: cor_start = 1'b0;
    endcase
  end

  tlk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  tlk_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x0    (cor_x),
    .y0    (cor_y),
    .done  (cor_done),
    .z     (cor_z)
  );

  assign sq_sum = sq_res_r + sq_bit_r;
  assign e_rnd  = to_units((ZW+1)'(cor_z));
  assign d_rnd  = to_units((ZW+1)'(a1_r) - (ZW+1)'(cor_z));

  always_comb begin
    if (d_rnd < (ZW+1)'(-SHOULDER_LIM))     d_clamped = 17'(-SHOULDER_LIM);
    else if (d_rnd > (ZW+1)'(SHOULDER_LIM)) d_clamped = 17'(SHOULDER_LIM);
    else                                    d_clamped = d_rnd[16:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_DX;
      S_DX:   state_nxt = S_DXW;
      S_DXW:  if (div_done) state_nxt = S_DY;
      S_DY:   state_nxt = S_DYW;
      S_DYW:  if (div_done) state_nxt = S_STEP;
      S_STEP: state_nxt = S_MXX;
      S_MXX:  state_nxt = S_MYY;
      S_MYY:  state_nxt = S_ML1;
      S_ML1:  state_nxt = S_ML2;
      S_ML2:  state_nxt = S_MLL;
      S_MLL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = clamp ? S_CC : S_CW;
      S_CW:   if (div_done) state_nxt = S_CC;
      S_CC:   state_nxt = S_SQI;
      S_SQI:  state_nxt = S_SQ;
      S_SQ:   if (sq_bit_r[0]) state_nxt = S_EL;
      S_EL:   state_nxt = S_ELW;
      S_ELW:  if (cor_done) state_nxt = S_A1;
      S_A1:   state_nxt = S_A1W;
      S_A1W:  if (cor_done) state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_A2;
      S_A2:   state_nxt = S_A2W;
      S_A2W:  if (cor_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = last_step ? S_IDLE : S_STEP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pen_x_r      <= '0;
      pen_y_r      <= 16'(UPPER_RESET) + 16'(LOWER_RESET);
      out_tvalid_r <= 1'b0;
      k_r          <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready)              out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: k_r <= '0;
        S_STEP: begin
          pen_x_r <= pen_x_r + dx_r[15:0];
          pen_y_r <= pen_y_r + dy_r[15:0];
        end
        S_FIN: if (out_free) k_r <= k_r + 1'b1;
        default: k_r <= k_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        tx_r  <= in_tdata[15:0];
        ty_r  <= in_tdata[31:16];
        sec_r <= sec_in;
      end
      S_DX, S_DY: dneg_r <= diff[16];
      S_DXW: dx_r <= dneg_r ? -div_q[16:0] : div_q[16:0];
      S_DYW: dy_r <= dneg_r ? -div_q[16:0] : div_q[16:0];
      S_MYY: acc_r <= prod_r;
      S_ML1: acc_r <= acc_r + prod_r;
      S_ML2, S_MLL: acc_r <= acc_r - prod_r;
      S_CHK: begin
        nneg_r <= acc_r[63];
        oor_r  <= clamp;
        if (den == '0)        c_r <= acc_r[63] ? -ONE_Q30 : ONE_Q30;
        else if (acc_r > den) c_r <= ONE_Q30;
        else                  c_r <= -ONE_Q30;
      end
      S_CW: c_r <= nneg_r ? -32'(div_q) : 32'(div_q);
      S_SQI: begin
        sq_n_r   <= 63'(64'sh1000000000000000 - prod_r);
        sq_res_r <= '0;
        sq_bit_r <= 63'(1) << 62;
      end
      S_SQ: begin
        if (sq_n_r >= sq_sum) begin
          sq_n_r   <= sq_n_r - sq_sum;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      S_ELW: if (cor_done) begin
        if (e_rnd[ZW])                       e_r <= '0;
        else if (e_rnd > (ZW+1)'(ELBOW_MAX)) e_r <= ELBOW_MAX;
        else                                 e_r <= e_rnd[14:0];
      end
      S_A1W: if (cor_done) a1_r <= cor_z;
      S_P2:  ya_r <= prod_r;
      S_FIN: if (out_free) begin
        ox_r    <= pen_x_r;
        oy_r    <= pen_y_r;
        osh_r   <= d_clamped;
        oel_r   <= e_r;
        ooor_r  <= oor_r;
        olast_r <= last_step;
      end
      default: acc_r <= acc_r;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DX))
    else $error("accepted transaction did not start delta setup");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside finish state");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (oel_r <= ELBOW_MAX && osh_r <= 17'sd46080 && osh_r >= -17'sd46080))
    else $error("joint angle out of range");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DXW || state_r == S_DYW || state_r == S_CW))
    else $error("divider finished while not awaited");

  a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == S_ELW || state_r == S_A1W || state_r == S_A2W))
    else $error("CORDIC finished while not awaited");

endmodule
`default_nettype wire
